// ----- design/slot_table_key_map_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the slot table key map
// Shared clocked assertion wrappers with active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef SLOT_TABLE_KEY_MAP_MACROS_SVH
`define SLOT_TABLE_KEY_MAP_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define STKM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define STKM_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  `STKM_ASSERT(lbl, clk, rst_n, !(expr), msg)

`endif

// ----- design/stkm_pkg.sv -----
// ----------------------------------------------------------------------------
// Slot table key map package
// Field widths, operation and status codes, and item structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stkm_pkg;

  localparam int STKM_ENTRIES     = 16;
  localparam int STKM_KEY_WIDTH   = 32;
  localparam int STKM_VALUE_WIDTH = 32;

  localparam int MODE_W     = 2;
  localparam int KEY_IN_W   = 32;
  localparam int VAL_IN_W   = 32;
  localparam int STATUS_W   = 2;
  localparam int SLOT_IDX_W = 4;
  localparam int OUT_VAL_W  = 32;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_PRESENT  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_INSERT,
    OP_REMOVE,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [KEY_IN_W-1:0] key;
    logic [VAL_IN_W-1:0] val;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_IDX_W-1:0] idx;
    logic [OUT_VAL_W-1:0]  value;
  } res_t;

endpackage

// ----- design/slot_table_key_map.sv -----
// ----------------------------------------------------------------------------
// Slot table key map
// Fully associative key table with lookup, insert and remove requests.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake     Fields
// request   in         push / full   mode_i, lookup_key_i, entry_value_i
// result    out        pop / empty   status_o, slot_index_o, stored_value_o
//
// Each item passes through the engine state S_MATCH (key match, table update,
// registered payload read), then S_RESP (result push). No new item is taken
// until S_RESP ends; results pass the command queue, engine and result queue.
// Reset clears all valid marks at once; no clearing pass.
// Both sides have 2-entry queues, so requests are taken while results wait.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slot_table_key_map import stkm_pkg::*; #(
  parameter int ENTRIES     = STKM_ENTRIES,
  parameter int KEY_WIDTH   = STKM_KEY_WIDTH,
  parameter int VALUE_WIDTH = STKM_VALUE_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [MODE_W-1:0]     mode_i,
  input  logic [KEY_IN_W-1:0]   lookup_key_i,
  input  logic [VAL_IN_W-1:0]   entry_value_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [STATUS_W-1:0]   status_o,
  output logic [SLOT_IDX_W-1:0] slot_index_o,
  output logic [OUT_VAL_W-1:0]  stored_value_o
);

  cmd_t                    cmd;
  logic                    cmd_empty, cmd_pop;
  res_t                    res_in, res_out;
  logic                    res_push, res_full;
  logic [$bits(res_t)-1:0] res_raw;

  stkm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .mode_i      (mode_i),
    .key_i       (lookup_key_i),
    .val_i       (entry_value_i),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd),
    .cmd_empty_o (cmd_empty)
  );

  stkm_engine #(
    .ENTRIES     (ENTRIES),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  stkm_fifo #(
    .WIDTH ($bits(res_t))
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_raw),
    .empty_o (empty)
  );

  assign res_out        = res_t'(res_raw);
  assign status_o       = res_out.status;
  assign slot_index_o   = res_out.idx;
  assign stored_value_o = res_out.value;

endmodule

// ----- design/stkm_fifo.sv -----
// ----------------------------------------------------------------------------
// Slot table key map queue
// Short first-in first-out buffer for command and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stkm_fifo import stkm_pkg::*; #(
  parameter int WIDTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0]      mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- design/stkm_front.sv -----
// ----------------------------------------------------------------------------
// Slot table key map front end
// Accepts request items, decodes the mode and queues commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stkm_front import stkm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [KEY_IN_W-1:0] key_i,
  input  logic [VAL_IN_W-1:0] val_i,
  input  logic                cmd_pop_i,
  output cmd_t                cmd_o,
  output logic                cmd_empty_o
);

  cmd_t                   cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_raw;

  always_comb begin
    cmd_in.key = key_i;
    cmd_in.val = val_i;
    case (mode_i)
      MODE_LOOKUP: cmd_in.op = OP_LOOKUP;
      MODE_INSERT: cmd_in.op = OP_INSERT;
      MODE_REMOVE: cmd_in.op = OP_REMOVE;
      default:     cmd_in.op = OP_NONE;
    endcase
  end

  stkm_fifo #(
    .WIDTH ($bits(cmd_t))
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_raw),
    .empty_o (cmd_empty_o)
  );

  assign cmd_o = cmd_t'(cmd_raw);

endmodule

// ----- design/stkm_engine.sv -----
// ----------------------------------------------------------------------------
// Slot table key map engine
// Parallel key match, lowest-free-slot search, table update and payload read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "slot_table_key_map_macros.svh"

module stkm_engine import stkm_pkg::*; #(
  parameter int ENTRIES     = STKM_ENTRIES,
  parameter int KEY_WIDTH   = STKM_KEY_WIDTH,
  parameter int VALUE_WIDTH = STKM_VALUE_WIDTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  logic cmd_empty_i,
  output logic cmd_pop_o,
  output res_t res_o,
  output logic res_push_o,
  input  logic res_full_i
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [1:0] {
    S_MATCH = 2'b01,
    S_RESP  = 2'b10
  } eng_state_e;

  eng_state_e state_q, state_d;

  logic [ENTRIES-1:0]     valid_q;
  logic [KEY_WIDTH-1:0]   key_q [ENTRIES];
  logic [VALUE_WIDTH-1:0] pay_mem [ENTRIES];
  logic [VALUE_WIDTH-1:0] rd_data_q;

  logic [KEY_WIDTH+KEY_IN_W-1:0]   key_x;
  logic [KEY_WIDTH-1:0]            key_w;
  logic [VALUE_WIDTH+VAL_IN_W-1:0] val_x;
  logic [VALUE_WIDTH-1:0]          val_w;

  logic [ENTRIES-1:0] match_vec;
  logic               hit, free;
  logic [IDX_W-1:0]   hit_idx, free_idx;
  logic               go, set_en, clr_en, rd_en;

  logic [STATUS_W-1:0]    status_q, status_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic                   use_mem_q, use_mem_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;

  logic [SLOT_IDX_W+IDX_W-1:0]      idx_x;
  logic [VALUE_WIDTH-1:0]           pay;
  logic [OUT_VAL_W+VALUE_WIDTH-1:0] pay_x;

  assign key_x = {{KEY_WIDTH{1'b0}}, cmd_i.key};
  assign key_w = key_x[KEY_WIDTH-1:0];
  assign val_x = {{VALUE_WIDTH{1'b0}}, cmd_i.val};
  assign val_w = val_x[VALUE_WIDTH-1:0];

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = valid_q[i] && (key_q[i] == key_w);
    end
  end

  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!valid_q[i]) begin
        free     = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign go        = (state_q == S_MATCH) && !cmd_empty_i && !res_full_i;
  assign cmd_pop_o = go;

  always_comb begin
    status_d  = ST_MISS;
    idx_d     = '0;
    use_mem_d = 1'b0;
    val_d     = '0;
    set_en    = 1'b0;
    clr_en    = 1'b0;
    rd_en     = 1'b0;
    case (cmd_i.op)
      OP_LOOKUP, OP_REMOVE: begin
        if (hit) begin
          status_d  = ST_PRESENT;
          idx_d     = hit_idx;
          use_mem_d = 1'b1;
          rd_en     = go;
          clr_en    = go && (cmd_i.op == OP_REMOVE);
        end
      end
      OP_INSERT: begin
        if (hit) begin
          status_d  = ST_PRESENT;
          idx_d     = hit_idx;
          use_mem_d = 1'b1;
          rd_en     = go;
        end else if (free) begin
          status_d = ST_INSERTED;
          idx_d    = free_idx;
          val_d    = val_w;
          set_en   = go;
        end else begin
          status_d = ST_FULL;
        end
      end
      default: begin
        status_d = ST_MISS;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_MATCH: if (go) state_d = S_RESP;
      S_RESP:  state_d = S_MATCH;
      default: state_d = S_MATCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_MATCH;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      if (set_en) begin
        valid_q[free_idx] <= 1'b1;
      end
      if (clr_en) begin
        valid_q[hit_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (set_en) begin
      key_q[free_idx] <= key_w;
    end
    if (go) begin
      status_q  <= status_d;
      idx_q     <= idx_d;
      use_mem_q <= use_mem_d;
      val_q     <= val_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (set_en) begin
      pay_mem[free_idx] <= val_w;
    end
    if (rd_en) begin
      rd_data_q <= pay_mem[hit_idx];
    end
  end

  assign idx_x = {{SLOT_IDX_W{1'b0}}, idx_q};
  assign pay   = use_mem_q ? rd_data_q : val_q;
  assign pay_x = {{OUT_VAL_W{1'b0}}, pay};

  assign res_push_o   = (state_q == S_RESP);
  assign res_o.status = status_q;
  assign res_o.idx    = idx_x[SLOT_IDX_W-1:0];
  assign res_o.value  = pay_x[OUT_VAL_W-1:0];

  `STKM_ASSERT_NEVER(a_unique_key, clk_i, rst_ni, !cmd_empty_i && !$onehot0(match_vec), "duplicate key in table")
  `STKM_ASSERT(a_resp_room, clk_i, rst_ni, (state_q == S_RESP) |-> !res_full_i, "result queue full")
  `STKM_ASSERT(a_fill_sets_valid, clk_i, rst_ni, set_en |=> valid_q[$past(free_idx)], "fill lost")

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// Slot table key map testbench
// Sends lookup, insert and remove requests to the key table and checks each
// result against a tracking copy of the table. A directed opening covers the
// corner cases, including a full table, duplicate inserts and the unused mode.
// Random phases with shifting operation mixes follow, with random gaps on
// both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import stkm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int KEY_POOL_SIZE = 24;
  localparam int PHASE_ITEMS = 170;
  localparam int MAX_PRINTED = 40;

  class slot_table_tracker;
    bit                    slot_used[STKM_ENTRIES];
    logic [KEY_IN_W-1:0]   slot_key[STKM_ENTRIES];
    logic [OUT_VAL_W-1:0]  slot_val[STKM_ENTRIES];
    res_t                  expected_replies[$];
    int                    mismatches;
    int                    checked;
    int                    status_seen[4];

    function new();
      for (int i = 0; i < STKM_ENTRIES; i++) begin
        slot_used[i] = 1'b0;
      end
      mismatches = 0;
      checked = 0;
      for (int s = 0; s < 4; s++) begin
        status_seen[s] = 0;
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) begin
        $display("MISMATCH at %0t: %s", $realtime, msg);
      end
    endtask

    function void apply_request(op_e op, logic [KEY_IN_W-1:0] key,
                                logic [VAL_IN_W-1:0] val);
      res_t r;
      int   hit;
      int   free_slot;
      r.status = ST_MISS;
      r.idx    = '0;
      r.value  = '0;
      hit = -1;
      free_slot = -1;
      for (int i = STKM_ENTRIES - 1; i >= 0; i--) begin
        if (slot_used[i] && slot_key[i] == key) hit = i;
        if (!slot_used[i]) free_slot = i;
      end
      case (op)
        OP_LOOKUP, OP_REMOVE: begin
          if (hit >= 0) begin
            r.status = ST_PRESENT;
            r.idx    = SLOT_IDX_W'(hit);
            r.value  = slot_val[hit];
            if (op == OP_REMOVE) slot_used[hit] = 1'b0;
          end
        end
        OP_INSERT: begin
          if (hit >= 0) begin
            r.status = ST_PRESENT;
            r.idx    = SLOT_IDX_W'(hit);
            r.value  = slot_val[hit];
          end else if (free_slot >= 0) begin
            slot_used[free_slot] = 1'b1;
            slot_key[free_slot]  = key;
            slot_val[free_slot]  = val;
            r.status = ST_INSERTED;
            r.idx    = SLOT_IDX_W'(free_slot);
            r.value  = val;
          end else begin
            r.status = ST_FULL;
          end
        end
        default: ;
      endcase
      expected_replies.push_back(r);
    endfunction

    task check_result(logic [STATUS_W-1:0] status,
                      logic [SLOT_IDX_W-1:0] idx,
                      logic [OUT_VAL_W-1:0] value);
      res_t want;
      checked++;
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d idx=%0d value=%h",
                                  status, idx, value));
        return;
      end
      want = expected_replies.pop_front();
      status_seen[want.status]++;
      if (status !== want.status)
        report_mismatch($sformatf("result %0d: status %0d, want %0d",
                                  checked, status, want.status));
      if (idx !== want.idx)
        report_mismatch($sformatf("result %0d: slot_index %0d, want %0d",
                                  checked, idx, want.idx));
      if (value !== want.value)
        report_mismatch($sformatf("result %0d: stored_value %h, want %h",
                                  checked, value, want.value));
    endtask

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  logic [MODE_W-1:0]     mode_i;
  logic [KEY_IN_W-1:0]   lookup_key_i;
  logic [VAL_IN_W-1:0]   entry_value_i;
  logic                  empty;
  logic                  pop;
  logic [STATUS_W-1:0]   status_o;
  logic [SLOT_IDX_W-1:0] slot_index_o;
  logic [OUT_VAL_W-1:0]  stored_value_o;

  slot_table_tracker     tracker;
  logic [KEY_IN_W-1:0]   key_pool[KEY_POOL_SIZE];
  bit                    calm;
  int                    requests_sent;
  int                    cycle_count;

  slot_table_key_map DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .mode_i         (mode_i),
    .lookup_key_i   (lookup_key_i),
    .entry_value_i  (entry_value_i),
    .empty          (empty),
    .pop            (pop),
    .status_o       (status_o),
    .slot_index_o   (slot_index_o),
    .stored_value_o (stored_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, tracker.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_request(op_e op, logic [KEY_IN_W-1:0] key,
                              logic [VAL_IN_W-1:0] val);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push          <= 1'b1;
    mode_i        <= op;
    lookup_key_i  <= key;
    entry_value_i <= val;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    tracker.apply_request(op, key, val);
    requests_sent++;
  endtask

  // hold off new requests until the table has answered everything
  task automatic drain_replies();
    push <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  function automatic op_e pick_op(int phase);
    int ins_pct[4]  = '{55, 30, 20, 60};
    int look_pct[4] = '{25, 35, 30, 20};
    int rem_pct[4]  = '{15, 30, 45, 15};
    int r;
    r = $urandom_range(0, 99);
    if (r < ins_pct[phase]) return OP_INSERT;
    if (r < ins_pct[phase] + look_pct[phase]) return OP_LOOKUP;
    if (r < ins_pct[phase] + look_pct[phase] + rem_pct[phase]) return OP_REMOVE;
    return OP_NONE;
  endfunction

  function automatic logic [KEY_IN_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    return $urandom;
  endfunction

  initial begin
    int gap;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      tracker.check_result(status_o, slot_index_o, stored_value_o);
    end
  end

  initial begin
    tracker = new();
    requests_sent = 0;
    cycle_count = 0;
    calm = 1'b0;
    push          <= 1'b0;
    mode_i        <= OP_LOOKUP;
    lookup_key_i  <= '0;
    entry_value_i <= '0;
    rst_ni        <= 1'b0;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < KEY_POOL_SIZE; i++) begin
      key_pool[i] = {15'($urandom_range(0, 32'h7FFF)), 1'b1, 16'(i)};
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed opening
    send_request(OP_LOOKUP, 32'h0000_0000, 32'h1234_5678);
    send_request(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h0000_0000, 32'hA5A5_A5A5);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_NONE,   32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
    for (int i = 2; i < 17; i++) begin
      send_request(OP_INSERT, key_pool[i], $urandom);
    end
    send_request(OP_INSERT, key_pool[17], 32'h5A5A_5A5A);
    send_request(OP_LOOKUP, key_pool[17], 32'h0000_0000);
    send_request(OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    drain_replies();

    for (int phase = 0; phase < 4; phase++) begin
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 25 == 0) calm = (phase == 1) || ($urandom_range(0, 3) == 0);
        send_request(pick_op(phase), pick_key(), $urandom);
      end
      calm = 1'b0;
      drain_replies();
    end

    repeat (10) @(posedge clk_i);
    if (tracker.pending() != 0)
      tracker.report_mismatch($sformatf("%0d results never arrived", tracker.pending()));

    $display("Run covered %0d requests and %0d results in %0d cycles:",
             requests_sent, tracker.checked, cycle_count);
    $display("  %0d present, %0d inserted, %0d not found, %0d table full",
             tracker.status_seen[ST_PRESENT], tracker.status_seen[ST_INSERTED],
             tracker.status_seen[ST_MISS], tracker.status_seen[ST_FULL]);
    if (tracker.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", tracker.mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
